// ===== rtl/multi_channel_compare_timer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Compare timer assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_COMPARE_TIMER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_COMPARE_TIMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mctu_pkg.sv =====
// ----------------------------------------------------------------------------
// Compare timer package
// Command kinds and result status codes of the multi-channel compare timer.
// ----------------------------------------------------------------------------
package mctu_pkg;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_ALLOC = 3'd1,
		KIND_START = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_QUERY = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2,
		ST_NO_FREE = 2'd3
	} status_t;

	localparam int unsigned DUR_W  = 24;
	localparam int unsigned MASK_W = 3;

endpackage

// ===== rtl/multi_channel_compare_timer_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-channel compare timer
// Virtual timers sharing one tick counter; one result beat per command beat.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   kind, channel, repeat_req, duration
//   rsp      out        rsp_valid / rsp_stall   status, channel_out, remaining,
//                                               expired_mask
//   cfg      in         cfg_valid / cfg_ready   cfg_data (reload adjust)
//
// One beat per cycle sustained while rsp_stall is low; each request beat is
// registered in the input register, then its result in the result register.
// All command work, including counter and compare updates, sits between
// the request register and the result register.
// rsp_stall holds the result register; req_stall rises only while a result
// is held and the request register is full.
// arst_n clears all timer state; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "multi_channel_compare_timer_unit_defines.svh"

module multi_channel_compare_timer_unit
	import mctu_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS  = 3,
	parameter int unsigned COUNTER_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        kind,
	input  logic [1:0]        channel,
	input  logic              repeat_req,
	input  logic [DUR_W-1:0]  duration,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic [1:0]        channel_out,
	output logic [DUR_W-1:0]  remaining,
	output logic [MASK_W-1:0] expired_mask
);

	localparam int unsigned CW = COUNTER_WIDTH;
	localparam int unsigned NC = NUM_CHANNELS;
	localparam logic [2:0]  NC_CODE = 3'(NUM_CHANNELS);
	localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

	// timer state
	logic [CW-1:0] tick_q;
	logic [3:0]    adj_q;
	logic [NC-1:0] alloc_q, active_q, rep_q;
	logic [CW-1:0] period_q [NC];
	logic [CW-1:0] cmp_q    [NC];

	logic [NC-1:0] alloc_d, active_d, rep_d;
	logic [CW-1:0] tick_d;
	logic [CW-1:0] period_d [NC];
	logic [CW-1:0] cmp_d    [NC];

	// request register
	logic             v_s1;
	logic [2:0]       kind_s1;
	logic [1:0]       ch_s1;
	logic             rep_s1;
	logic [DUR_W-1:0] dur_s1;

	// result register
	logic              v_s2;
	status_t           status_s2;
	logic [1:0]        chout_s2;
	logic [DUR_W-1:0]  rem_s2;
	logic [MASK_W-1:0] mask_s2;

	status_t           status_c;
	logic [1:0]        chout_c;
	logic [DUR_W-1:0]  rem_c;
	logic [MASK_W-1:0] mask_c;

	logic adv, fire;

	assign adv       = !v_s2 || !rsp_stall;
	assign fire      = v_s1 && adv;
	assign req_stall = v_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			kind_s1 <= kind;
			ch_s1   <= channel;
			rep_s1  <= repeat_req;
			dur_s1  <= duration;
		end
	end

	// command decode and state update
	always_comb begin
		logic          ch_ok, found, running;
		logic [NC-1:0] sel, hit;
		logic          s_alloc, s_active;
		logic [CW-1:0] s_cmp, now, dur_cw;
		logic [31:0]   diff32;

		ch_ok    = {1'b0, ch_s1} < NC_CODE;
		running  = |active_q;
		now      = tick_q + CW'(1);
		dur_cw   = CW'({8'd0, dur_s1});
		s_alloc  = 1'b0;
		s_active = 1'b0;
		s_cmp    = '0;
		found    = 1'b0;
		diff32   = '0;
		for (int i = 0; i < NC; i++) begin
			sel[i] = ch_ok && (ch_s1 == 2'(i));
			hit[i] = running && active_q[i] && (cmp_q[i] == now);
			if (sel[i]) begin
				s_alloc  = alloc_q[i];
				s_active = active_q[i];
				s_cmp    = cmp_q[i];
			end
		end

		alloc_d  = alloc_q;
		active_d = active_q;
		rep_d    = rep_q;
		tick_d   = tick_q;
		period_d = period_q;
		cmp_d    = cmp_q;
		status_c = ST_OK;
		chout_c  = ch_s1;
		rem_c    = '0;
		mask_c   = '0;

		unique case (kind_t'(kind_s1))
			KIND_TICK: begin
				if (running) begin
					tick_d = now;
					for (int i = 0; i < NC; i++) begin
						if (hit[i]) begin
							if (rep_q[i]) begin
								cmp_d[i] = now + period_q[i] - CW'(adj_q);
							end else begin
								active_d[i] = 1'b0;
							end
						end
					end
					mask_c = MASK_W'(hit);
				end
			end
			KIND_ALLOC: begin
				status_c = ST_NO_FREE;
				chout_c  = '0;
				for (int i = 0; i < NC; i++) begin
					if (!found && !alloc_q[i]) begin
						found       = 1'b1;
						alloc_d[i]  = 1'b1;
						active_d[i] = 1'b0;
						rep_d[i]    = rep_s1;
						status_c    = ST_OK;
						chout_c     = 2'(i);
					end
				end
			end
			KIND_START: begin
				if (!s_alloc) begin
					status_c = ST_INVALID;
				end else if (s_active) begin
					status_c = ST_BUSY;
				end else if ({8'd0, dur_s1} >= CNT_MAX) begin
					status_c = ST_INVALID;
				end else begin
					for (int i = 0; i < NC; i++) begin
						if (sel[i]) begin
							cmp_d[i]    = tick_q + dur_cw;
							period_d[i] = dur_cw;
							active_d[i] = 1'b1;
						end
					end
				end
			end
			KIND_STOP: begin
				if (!s_active) begin
					status_c = ST_INVALID;
				end else begin
					active_d = active_q & ~sel;
				end
			end
			KIND_QUERY: begin
				if (!ch_ok) begin
					status_c = ST_INVALID;
				end else if (s_active) begin
					diff32 = 32'(s_cmp - tick_q);
					rem_c  = diff32[DUR_W-1:0];
				end
			end
			default: begin
				status_c = ST_INVALID;
			end
		endcase

		// counter stops and clears once nothing is active
		if (active_d == '0) begin
			tick_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			adj_q    <= '0;
			alloc_q  <= '0;
			active_q <= '0;
			rep_q    <= '0;
			period_q <= '{default: '0};
			cmp_q    <= '{default: '0};
		end else begin
			if (cfg_valid && cfg_ready) begin
				adj_q <= cfg_data;
			end
			if (fire) begin
				tick_q   <= tick_d;
				alloc_q  <= alloc_d;
				active_q <= active_d;
				rep_q    <= rep_d;
				period_q <= period_d;
				cmp_q    <= cmp_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_c;
			chout_s2  <= chout_c;
			rem_s2    <= rem_c;
			mask_s2   <= mask_c;
		end
	end

	assign rsp_valid    = v_s2;
	assign status       = status_s2;
	assign channel_out  = chout_s2;
	assign remaining    = rem_s2;
	assign expired_mask = mask_s2;

	`MCTU_ASSERT_NOW(a_idle_cleared, active_q == '0, tick_q == '0, "counter not cleared while idle")
	`MCTU_ASSERT_NOW(a_active_alloc, 1'b1, (active_q & ~alloc_q) == '0, "active channel not allocated")
	`MCTU_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a held result")
	`MCTU_ASSERT_NEXT(a_tick_hold, fire && kind_s1 != KIND_TICK && active_d != '0, tick_q == $past(tick_q), "counter moved on a non-tick beat")
	`MCTU_ASSERT_NOW(a_mask_ok, rsp_valid && expired_mask != '0, status == ST_OK, "expiry reported with error status")

endmodule

// ===== dv/multi_channel_compare_timer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Compare timer testbench
// Drives command beats into the timer and predicts every result beat from a
// behavioral copy of the counter and channel state. Runs a directed opening
// and then random command streams under four reload adjust settings, with
// random gaps and stalls on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module multi_channel_compare_timer_unit_tb;
	import mctu_pkg::*;

	localparam int unsigned CHANNELS         = 3;
	localparam int unsigned RANDOM_PER_PHASE = 290;
	localparam int unsigned CYCLE_LIMIT      = 300000;
	localparam logic [2:0]  KIND_LAST_CODE   = '1;
	localparam logic [DUR_W-1:0] DUR_REJECT  = '1;
	localparam logic [DUR_W-1:0] DUR_LONGEST = DUR_REJECT - 1'b1;

	typedef struct packed {
		logic [2:0]       kind;
		logic [1:0]       channel;
		logic             repeat_req;
		logic [DUR_W-1:0] duration;
	} timer_cmd_t;

	typedef struct packed {
		status_t           status;
		logic [1:0]        channel_out;
		logic [DUR_W-1:0]  remaining;
		logic [MASK_W-1:0] expired_mask;
	} timer_rsp_t;

	// Behavioral copy of the timer; one expected result per command beat.
	class timer_scoreboard;
		bit [3:0]       adjust;
		bit [DUR_W-1:0] count;
		bit             running;
		int unsigned    active_n;
		bit             allocated [CHANNELS];
		bit             active [CHANNELS];
		bit             repeating [CHANNELS];
		bit [DUR_W-1:0] period [CHANNELS];
		bit [DUR_W-1:0] compare_at [CHANNELS];
		timer_rsp_t     expected_rsp [$];
		int unsigned    errors;

		function void set_adjust(bit [3:0] value);
			adjust = value;
		endfunction

		function int unsigned outstanding();
			return expected_rsp.size();
		endfunction

		function void stop_channel(int unsigned c);
			active[c] = 0;
			if (active_n > 0)
				active_n--;
			if (active_n == 0) begin
				running = 0;
				count   = '0;
			end
		endfunction

		function void note_request(timer_cmd_t cmd);
			timer_rsp_t     e;
			bit             in_range;
			int unsigned    c;
			bit [DUR_W-1:0] now;
			bit [MASK_W-1:0] hit;
			e.status       = ST_OK;
			e.channel_out  = cmd.channel;
			e.remaining    = '0;
			e.expired_mask = '0;
			in_range = cmd.channel < CHANNELS;
			c = in_range ? int'(cmd.channel) : 0;
			case (cmd.kind)
				KIND_TICK: begin
					if (running) begin
						count = count + 1'b1;
						now = count;
						hit = '0;
						for (int i = 0; i < CHANNELS; i++)
							if (active[i] && compare_at[i] == now)
								hit[i] = 1'b1;
						// reloads all use this tick's count, even if a stop cleared it
						for (int i = 0; i < CHANNELS; i++) begin
							if (!hit[i])
								continue;
							if (repeating[i])
								compare_at[i] = now + period[i] - DUR_W'(adjust);
							else
								stop_channel(i);
						end
						e.expired_mask = hit;
					end
				end
				KIND_ALLOC: begin
					e.status      = ST_NO_FREE;
					e.channel_out = '0;
					for (int i = 0; i < CHANNELS; i++) begin
						if (!allocated[i]) begin
							allocated[i]  = 1;
							active[i]     = 0;
							repeating[i]  = cmd.repeat_req;
							e.status      = ST_OK;
							e.channel_out = 2'(i);
							break;
						end
					end
				end
				KIND_START: begin
					if (!in_range || !allocated[c])
						e.status = ST_INVALID;
					else if (active[c])
						e.status = ST_BUSY;
					else if (cmd.duration == DUR_REJECT)
						e.status = ST_INVALID;
					else begin
						compare_at[c] = count + cmd.duration;
						period[c]     = cmd.duration;
						active[c]     = 1;
						running       = 1;
						active_n++;
					end
				end
				KIND_STOP: begin
					if (!in_range || !active[c])
						e.status = ST_INVALID;
					else
						stop_channel(c);
				end
				KIND_QUERY: begin
					if (!in_range)
						e.status = ST_INVALID;
					else if (active[c])
						e.remaining = compare_at[c] - count;
				end
				default: e.status = ST_INVALID;
			endcase
			expected_rsp.push_back(e);
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			errors++;
			$error("%s: expected %0d, actual %0d", field, want, got);
		endfunction

		function void check_response(timer_rsp_t got);
			timer_rsp_t e;
			if (expected_rsp.size() == 0) begin
				errors++;
				$error("result beat with no command outstanding");
				return;
			end
			e = expected_rsp.pop_front();
			if (got.status !== e.status)
				report("status", e.status, got.status);
			if (got.channel_out !== e.channel_out)
				report("channel_out", e.channel_out, got.channel_out);
			if (got.remaining !== e.remaining)
				report("remaining", e.remaining, got.remaining);
			if (got.expired_mask !== e.expired_mask)
				report("expired_mask", e.expired_mask, got.expired_mask);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [3:0]        cfg_data;
	logic              req_valid;
	logic              req_stall;
	logic [2:0]        kind;
	logic [1:0]        channel;
	logic              repeat_req;
	logic [DUR_W-1:0]  duration;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [1:0]        status;
	logic [1:0]        channel_out;
	logic [DUR_W-1:0]  remaining;
	logic [MASK_W-1:0] expired_mask;

	logic              hold_rsp;
	int unsigned       beats_in;
	timer_scoreboard   sb;

	multi_channel_compare_timer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.channel      (channel),
		.repeat_req   (repeat_req),
		.duration     (duration),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.channel_out  (channel_out),
		.remaining    (remaining),
		.expired_mask (expired_mask)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic timer_cmd_t make_cmd(logic [2:0] k, logic [1:0] ch, logic rep,
			logic [DUR_W-1:0] dur);
		timer_cmd_t cmd;
		cmd.kind       = k;
		cmd.channel    = ch;
		cmd.repeat_req = rep;
		cmd.duration   = dur;
		return cmd;
	endfunction

	// Mostly ticks so channels actually run out; short periods dominate.
	function automatic timer_cmd_t random_cmd();
		timer_cmd_t  cmd;
		int unsigned pick;
		int unsigned span;
		cmd.kind       = KIND_TICK;
		cmd.channel    = 2'($urandom_range(0, 3));
		cmd.repeat_req = 1'($urandom_range(0, 1));
		cmd.duration   = DUR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			cmd.kind = KIND_TICK;
		end else if (pick < 72) begin
			cmd.kind = KIND_START;
			if ($urandom_range(0, 19) != 0)
				cmd.channel = 2'($urandom_range(0, CHANNELS - 1));
			span = $urandom_range(0, 99);
			if (span < 70)
				cmd.duration = DUR_W'($urandom_range(0, 24));
			else if (span < 85)
				cmd.duration = DUR_W'($urandom_range(0, 200));
			else if (span < 95)
				cmd.duration = DUR_W'($urandom);
			else
				cmd.duration = $urandom_range(0, 1) ? DUR_REJECT : DUR_LONGEST;
		end else if (pick < 80) begin
			cmd.kind = KIND_STOP;
		end else if (pick < 92) begin
			cmd.kind = KIND_QUERY;
		end else if (pick < 96) begin
			cmd.kind = KIND_ALLOC;
		end else begin
			cmd.kind = 3'($urandom_range(int'(KIND_QUERY) + 1, int'(KIND_LAST_CODE)));
		end
		return cmd;
	endfunction

	task automatic send_cmd(timer_cmd_t cmd);
		int unsigned gap;
		gap = (beats_in % 50 < 12) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		kind       <= cmd.kind;
		channel    <= cmd.channel;
		repeat_req <= cmd.repeat_req;
		duration   <= cmd.duration;
		do @(posedge clk); while (req_stall);
		sb.note_request(cmd);
		beats_in++;
	endtask

	task automatic write_adjust(logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_adjust(value);
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// result side: random stall after each beat, plus the long hold-off
	initial begin
		int unsigned stall_left;
		int unsigned rx_cycles;
		timer_rsp_t  got;
		stall_left = 0;
		rx_cycles  = 0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				got.status       = status_t'(status);
				got.channel_out  = channel_out;
				got.remaining    = remaining;
				got.expired_mask = expired_mask;
				sb.check_response(got);
				stall_left = (rx_cycles % 150 < 40) ? 0 : $urandom_range(0, 3);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rsp_stall <= hold_rsp || stall_left > 0;
		end
	end

	// fills the pipe: results held while commands keep coming
	initial begin
		while (beats_in < 150)
			@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (60) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		timer_cmd_t opening [$];
		bit [3:0]   adjust_plan [4];
		sb = new();
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		req_valid  <= 1'b0;
		kind       <= KIND_TICK;
		channel    <= '0;
		repeat_req <= 1'b0;
		duration   <= '0;
		rsp_stall  <= 1'b0;
		hold_rsp   <= 1'b0;
		beats_in   = 0;

		// nothing allocated: stopped tick, idle query, bad start and stop, unused kinds
		opening.push_back(make_cmd(KIND_TICK, 0, 0, '0));
		opening.push_back(make_cmd(KIND_QUERY, 0, 1, '1));
		opening.push_back(make_cmd(KIND_START, 0, 0, 5));
		opening.push_back(make_cmd(KIND_STOP, 0, 0, 0));
		for (int k = int'(KIND_QUERY) + 1; k <= int'(KIND_LAST_CODE); k++)
			opening.push_back(make_cmd(3'(k), 0, 0, 0));
		// ch0 repeating, ch1 single-shot, ch2 repeating, then none left
		opening.push_back(make_cmd(KIND_ALLOC, 0, 1, 0));
		opening.push_back(make_cmd(KIND_ALLOC, 0, 0, 0));
		opening.push_back(make_cmd(KIND_ALLOC, 0, 1, 0));
		opening.push_back(make_cmd(KIND_ALLOC, 3, 1, 0));
		opening.push_back(make_cmd(KIND_START, 3, 0, 4));
		opening.push_back(make_cmd(KIND_STOP, 3, 0, 0));
		opening.push_back(make_cmd(KIND_START, 1, 0, DUR_REJECT));
		opening.push_back(make_cmd(KIND_START, 0, 0, 3));
		opening.push_back(make_cmd(KIND_START, 0, 0, DUR_REJECT));
		opening.push_back(make_cmd(KIND_START, 1, 0, DUR_LONGEST));
		opening.push_back(make_cmd(KIND_START, 2, 0, 3));
		// ch0 and ch2 expire together on the third tick
		repeat (3) opening.push_back(make_cmd(KIND_TICK, 0, 0, 0));
		opening.push_back(make_cmd(KIND_QUERY, 2, 0, 0));
		opening.push_back(make_cmd(KIND_STOP, 1, 0, 0));
		opening.push_back(make_cmd(KIND_START, 1, 0, 0));
		opening.push_back(make_cmd(KIND_QUERY, 1, 0, 0));
		opening.push_back(make_cmd(KIND_STOP, 0, 0, 0));
		opening.push_back(make_cmd(KIND_STOP, 1, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		adjust_plan = '{4'd0, 4'd15, 4'd2, 4'($urandom_range(1, 14))};
		for (int p = 0; p < 4; p++) begin
			write_adjust(adjust_plan[p]);
			if (p == 0)
				foreach (opening[i])
					send_cmd(opening[i]);
			repeat (RANDOM_PER_PHASE)
				send_cmd(random_cmd());
			req_valid <= 1'b0;
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
